// ===== rtl/pse_pkg.sv =====
// Shared types, codes and symbol helpers for the postfix stack evaluator.
package pse_pkg;

	localparam int DATA_W      = 32;
	localparam int NUM_LETTERS = 52;
	localparam int SLOT_W      = 6;
	localparam int DEF_STACK_DEPTH = 64;

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_STAR  = 8'h2A;
	localparam logic [7:0] SYM_SLASH = 8'h2F;
	localparam logic [7:0] SYM_CARET = 8'h5E;
	localparam logic [7:0] SYM_LO_A  = 8'h61;
	localparam logic [7:0] SYM_LO_Z  = 8'h7A;
	localparam logic [7:0] SYM_UP_A  = 8'h41;
	localparam logic [7:0] SYM_UP_Z  = 8'h5A;

	typedef enum logic [1:0] {
		OP_BIND  = 2'd0,
		OP_EVAL  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_OVER    = 3'd2,
		ST_DIVZ    = 3'd3,
		ST_UNBOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT_MUL,
		S_WAIT_DIV,
		S_POW,
		S_POW_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= SYM_LO_A) && (c <= SYM_LO_Z)) || ((c >= SYM_UP_A) && (c <= SYM_UP_Z));
	endfunction

	function automatic logic [SLOT_W-1:0] letter_slot(input logic [7:0] c);
		logic [7:0] s;
		if (c >= SYM_LO_A) begin
			s = c - SYM_LO_A;
		end else begin
			s = c - SYM_UP_A + 8'd26;
		end
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return (c == SYM_PLUS) || (c == SYM_MINUS) || (c == SYM_STAR) ||
		       (c == SYM_SLASH) || (c == SYM_CARET);
	endfunction

endpackage

// ===== rtl/pse_mul.sv =====
// Bit-serial shift-add multiplier, low 32 bits of the product.
module pse_mul import pse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output unit_stat_t        stat,
	output logic [DATA_W-1:0] prod
);

	localparam int CNT_W = $clog2(DATA_W);

	logic [DATA_W-1:0] mcand_q, mplier_q, acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= a;
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
			mcand_q  <= {mcand_q[DATA_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[DATA_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule

// ===== rtl/pse_div.sv =====
// Bit-serial restoring divider on unsigned magnitudes.
module pse_div import pse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] num,
	input  logic [DATA_W-1:0] den,
	output unit_stat_t        stat,
	output logic [DATA_W-1:0] quo
);

	localparam int CNT_W = $clog2(DATA_W);

	logic [DATA_W-1:0] rem_q, quo_q, den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [DATA_W:0]   shifted, diff;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
// Top level: postfix evaluator with operand stack, letter table and serial units.
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   tuser: opcode[1:0]; tdata: symbol[7:0], bind_value[39:8]
// m_axis    out  tdata: top_value[31:0], stack_depth, status (3 bits), zero fill
//
// One item at a time. Bind, clear, push, + and - go from EXEC straight to DONE;
// * and / wait on the bit-serial multiplier or divider; ^ runs one pair of
// serial multiplies per exponent bit.
// arst_n empties the stack and unbinds all letters; memories need no clearing.
// A result held by a stalled m_axis does not keep the block from taking the next
// item; that item waits in DONE until the held result is taken.
module postfix_stack_evaluator import pse_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	localparam int CW    = $clog2(STACK_DEPTH + 1),
	localparam int OUT_W = ((DATA_W + CW + 3 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [39:0]      s_axis_tdata,   // symbol, bind_value
	input  logic [1:0]       s_axis_tuser,   // opcode
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // top_value, stack_depth, status
);

	localparam int AW = $clog2(STACK_DEPTH);

	state_t               state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_m2;
	logic [DATA_W-1:0]    top_q, bval_q, letter_rd_q, sec_rd_q;
	logic [DATA_W-1:0]    pacc_q, pbase_q, pexp_q;
	logic [7:0]           sym_q;
	opcode_t              opc_q;
	status_t              st_q, st_val;
	logic                 st_we, qneg_q;
	logic [NUM_LETTERS-1:0] bound_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_W-1:0] letter_mem [NUM_LETTERS];

	logic              accept, push, commit, bind_we, clr, out_load;
	logic              mul_start, div_start, pow_init, pow_step;
	logic [DATA_W-1:0] res, mul_a, mul_b, prod0, prod1, quo, a_val, b_val;
	logic [SLOT_W-1:0] in_slot, sym_slot;
	logic [AW-1:0]     sec_addr, stk_waddr;
	logic [DATA_W-1:0] stk_wdata;
	logic              sym_letter;
	unit_stat_t        mul0_stat, mul1_stat, div_stat;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_slot       = letter_slot(s_axis_tdata[7:0]);
	assign sym_slot      = letter_slot(sym_q);
	assign sym_letter    = is_letter(sym_q);
	assign cnt_m2        = cnt_q - CW'(2);
	assign sec_addr      = cnt_m2[AW-1:0];
	assign a_val         = sec_rd_q;
	assign b_val         = top_q;

	// Serial arithmetic: mul0 does * and the accumulate of ^, mul1 squares the base
	pse_mul u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .stat(mul0_stat), .prod(prod0)
	);

	pse_mul u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(pbase_q), .b(pbase_q), .stat(mul1_stat), .prod(prod1)
	);

	pse_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(a_val[DATA_W-1] ? (~a_val + 1'b1) : a_val),
		.den(b_val[DATA_W-1] ? (~b_val + 1'b1) : b_val),
		.stat(div_stat), .quo(quo)
	);

	// Sequencer: decode in EXEC, wait on a serial unit, commit, then hand off the result
	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		commit    = 1'b0;
		res       = '0;
		bind_we   = 1'b0;
		clr       = 1'b0;
		st_we     = 1'b0;
		st_val    = ST_OK;
		mul_start = 1'b0;
		mul_a     = a_val;
		mul_b     = b_val;
		div_start = 1'b0;
		pow_init  = 1'b0;
		pow_step  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
					st_we   = 1'b1;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (opc_q)
					OP_BIND: begin
						bind_we = sym_letter && !bound_q[sym_slot];
					end
					OP_CLEAR: begin
						clr = 1'b1;
					end
					OP_EVAL: begin
						if (sym_letter) begin
							if (!bound_q[sym_slot]) begin
								st_we  = 1'b1;
								st_val = ST_UNBOUND;
							end else if (cnt_q == CW'(STACK_DEPTH)) begin
								st_we  = 1'b1;
								st_val = ST_OVER;
							end else begin
								push = 1'b1;
							end
						end else if (is_operator(sym_q)) begin
							if (cnt_q < CW'(2)) begin
								st_we  = 1'b1;
								st_val = ST_UNDER;
							end else begin
								case (sym_q)
									SYM_PLUS: begin
										commit = 1'b1;
										res    = a_val + b_val;
									end
									SYM_MINUS: begin
										commit = 1'b1;
										res    = a_val - b_val;
									end
									SYM_STAR: begin
										mul_start = 1'b1;
										state_d   = S_WAIT_MUL;
									end
									SYM_SLASH: begin
										if (b_val == '0) begin
											st_we  = 1'b1;
											st_val = ST_DIVZ;
										end else begin
											div_start = 1'b1;
											state_d   = S_WAIT_DIV;
										end
									end
									default: begin
										// power; negative exponent handled directly
										if (b_val[DATA_W-1]) begin
											if (a_val == DATA_W'(1)) begin
												commit = 1'b1;
												res    = DATA_W'(1);
											end else if (a_val == '1) begin
												commit = 1'b1;
												res    = b_val[0] ? '1 : DATA_W'(1);
											end else if (a_val == '0) begin
												st_we  = 1'b1;
												st_val = ST_DIVZ;
											end else begin
												commit = 1'b1;
											end
										end else begin
											pow_init = 1'b1;
											state_d  = S_POW;
										end
									end
								endcase
							end
						end
					end
					default: ;
				endcase
			end
			S_WAIT_MUL: begin
				if (mul0_stat.done) begin
					commit  = 1'b1;
					res     = prod0;
					state_d = S_DONE;
				end
			end
			S_WAIT_DIV: begin
				if (div_stat.done) begin
					commit  = 1'b1;
					res     = qneg_q ? (~quo + 1'b1) : quo;
					state_d = S_DONE;
				end
			end
			S_POW: begin
				if (pexp_q == '0) begin
					commit  = 1'b1;
					res     = pacc_q;
					state_d = S_DONE;
				end else begin
					mul_start = 1'b1;
					mul_a     = pacc_q;
					mul_b     = pbase_q;
					state_d   = S_POW_WAIT;
				end
			end
			S_POW_WAIT: begin
				if (mul0_stat.done) begin
					pow_step = 1'b1;
					state_d  = S_POW;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: depth, letter bindings, status, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			bound_q     <= '0;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				cnt_q   <= '0;
				bound_q <= '0;
			end else if (push) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (commit) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (bind_we) begin
				bound_q[sym_slot] <= 1'b1;
			end
			if (st_we) begin
				st_q <= st_val;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the item, track the top entry and the power loop registers
	always_ff @(posedge clk) begin
		if (accept) begin
			opc_q  <= opcode_t'(s_axis_tuser);
			sym_q  <= s_axis_tdata[7:0];
			bval_q <= s_axis_tdata[39:8];
		end
		if (push) begin
			top_q <= letter_rd_q;
		end else if (commit) begin
			top_q <= res;
		end
		if (div_start) begin
			qneg_q <= a_val[DATA_W-1] ^ b_val[DATA_W-1];
		end
		if (pow_init) begin
			pacc_q  <= DATA_W'(1);
			pbase_q <= a_val;
			pexp_q  <= b_val;
		end else if (pow_step) begin
			if (pexp_q[0]) begin
				pacc_q <= prod0;
			end
			pbase_q <= prod1;
			pexp_q  <= {1'b0, pexp_q[DATA_W-1:1]};
		end
		if (out_load) begin
			out_data_q <= OUT_W'({st_q, cnt_q, (cnt_q != '0) ? top_q : '0});
		end
	end

	// Operand stack: one write port, registered read of the second entry
	assign stk_waddr = push ? cnt_q[AW-1:0] : sec_addr;
	assign stk_wdata = push ? letter_rd_q : res;

	always_ff @(posedge clk) begin
		if (push || commit) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		sec_rd_q <= stack_mem[sec_addr];
	end

	// Letter table: read at accept with the incoming symbol
	always_ff @(posedge clk) begin
		if (bind_we) begin
			letter_mem[sym_slot] <= bval_q;
		end
		letter_rd_q <= letter_mem[in_slot];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Depth never exceeds the stack size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// An accepted item is decoded in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted item not decoded");

	// Multiplier completions only arrive while the sequencer waits on them
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul0_stat.done |-> (state_q == S_WAIT_MUL || state_q == S_POW_WAIT))
		else $error("stray multiplier completion");

	// Divider completions only arrive while waiting on the divider
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_WAIT_DIV)
		else $error("stray divider completion");

endmodule

// ===== sim/pse_checker.sv =====
// Scoreboard for the postfix stack evaluator: predicts each result and compares it.
module pse_checker import pse_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	localparam int CW    = $clog2(STACK_DEPTH + 1),
	localparam int OUT_W = ((DATA_W + CW + 3 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [39:0]      s_axis_tdata,
	input  logic [1:0]       s_axis_tuser,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0]   top;
		logic [CW-1:0] depth;
		status_t       status;
	} eval_result_t;

	logic [31:0] stack_mem [STACK_DEPTH];
	int          stack_cnt;
	logic [31:0] letter_val [NUM_LETTERS];
	logic        letter_ok [NUM_LETTERS];
	eval_result_t result_queue [$];

	assign pending = result_queue.size();

	function automatic int slot_of(logic [7:0] c);
		if (c >= SYM_LO_A && c <= SYM_LO_Z) return c - SYM_LO_A;
		if (c >= SYM_UP_A && c <= SYM_UP_Z) return c - SYM_UP_A + 26;
		return -1;
	endfunction

	function automatic logic [31:0] neg32(logic [31:0] v);
		return 32'd0 - v;
	endfunction

	// Execute one symbol against the local stack and letter table.
	task automatic evaluate_item(opcode_t op, logic [7:0] sym, logic [31:0] bval);
		int slot;
		logic [31:0] a, b, r, mn, md, q, base, ex;
		logic err;
		eval_result_t res;
		slot = slot_of(sym);
		res.status = ST_OK;
		err = 1'b0;
		r = '0;
		case (op)
			OP_BIND: begin
				if (slot >= 0 && !letter_ok[slot]) begin
					letter_ok[slot] = 1'b1;
					letter_val[slot] = bval;
				end
			end
			OP_CLEAR: begin
				stack_cnt = 0;
				foreach (letter_ok[i]) letter_ok[i] = 1'b0;
			end
			OP_EVAL: begin
				if (slot >= 0) begin
					if (!letter_ok[slot]) res.status = ST_UNBOUND;
					else if (stack_cnt >= STACK_DEPTH) res.status = ST_OVER;
					else begin
						stack_mem[stack_cnt] = letter_val[slot];
						stack_cnt++;
					end
				end else if (is_operator(sym)) begin
					if (stack_cnt < 2) res.status = ST_UNDER;
					else begin
						b = stack_mem[stack_cnt-1];
						a = stack_mem[stack_cnt-2];
						if (sym == SYM_PLUS) r = a + b;
						else if (sym == SYM_MINUS) r = a - b;
						else if (sym == SYM_STAR) r = a * b;
						else if (sym == SYM_SLASH) begin
							if (b == 0) err = 1'b1;
							else begin
								mn = a[31] ? neg32(a) : a;
								md = b[31] ? neg32(b) : b;
								q = mn / md;
								r = (a[31] != b[31]) ? neg32(q) : q;
							end
						end else begin
							// negative exponent: only unit bases survive
							if (b[31]) begin
								if (a == 32'd1) r = 32'd1;
								else if (a == '1) r = b[0] ? '1 : 32'd1;
								else begin
									r = '0;
									err = (a == 0);
								end
							end else begin
								r = 32'd1;
								base = a;
								ex = b;
								while (ex != 0) begin
									if (ex[0]) r = r * base;
									base = base * base;
									ex = ex >> 1;
								end
							end
						end
						if (err) res.status = ST_DIVZ;
						else begin
							stack_cnt--;
							stack_mem[stack_cnt-1] = r;
						end
					end
				end
			end
			default: ;
		endcase
		res.top = (stack_cnt > 0) ? stack_mem[stack_cnt-1] : '0;
		res.depth = CW'(stack_cnt);
		result_queue.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		eval_result_t want, got;
		if (!arst_n) begin
			stack_cnt = 0;
			foreach (letter_ok[i]) letter_ok[i] = 1'b0;
			result_queue.delete();
			fail_count = 0;
		end else begin
			// check before predict: a result never belongs to the item taken in the same cycle
			if (m_axis_tvalid && m_axis_tready) begin
				got.top = m_axis_tdata[31:0];
				got.depth = m_axis_tdata[32 +: CW];
				got.status = status_t'(m_axis_tdata[32+CW +: 3]);
				if (result_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: top %h depth %0d status %0d",
							got.top, got.depth, got.status);
				end else begin
					want = result_queue.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
								want.top, want.depth, want.status,
								got.top, got.depth, got.status);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				evaluate_item(opcode_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8]);
		end
	end
endmodule

// ===== sim/tb.sv =====
// Testbench top: drives symbols into the evaluator and gives the verdict.
module tb import pse_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEF_STACK_DEPTH;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int OUT_W = ((DATA_W + CW + 3 + 7) / 8) * 8;
	// allow for power with a long exponent and for receiver stalls
	localparam int IDLE_LIMIT = 20000;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [39:0]      s_axis_tdata;
	logic [1:0]       s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	int               fail_count;
	int               pending;
	int               idle_cycles;
	bit               hold_sink;

	postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) DUT (.*);

	pse_checker #(.STACK_DEPTH(DEPTH)) scoreboard (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hold reset low from the start, then release once
	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	// Receiver: random stalls on its own pattern; hold off fully while hold_sink is set.
	initial begin
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_sink) m_axis_tready <= 0;
			else if ($urandom_range(0, 99) < 3) m_axis_tready <= 1;
			else m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Offer one item and hold it until accepted.
	task automatic send_item(opcode_t op, logic [7:0] sym, logic [31:0] bval);
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {bval, sym};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic pause_idle(int n);
		s_axis_tvalid <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		int k;
		k = $urandom_range(0, 51);
		return (k < 26) ? 8'(SYM_LO_A + k) : 8'(SYM_UP_A + (k - 26));
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 4))
			0: return SYM_PLUS;
			1: return SYM_MINUS;
			2: return SYM_STAR;
			3: return SYM_SLASH;
			default: return SYM_CARET;
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return 32'd0;
			4: return 32'd1;
			5: return $urandom_range(0, 9) - 4;
			default: return $urandom();
		endcase
	endfunction

	// one expression: bind 2 to 6 letters, push random letters and some operators, fold with operators
	task automatic send_expression();
		int n;
		logic [7:0] ltr;
		n = $urandom_range(2, 6);
		repeat (n) send_item(OP_BIND, pick_letter(), pick_value());
		repeat (n + 1) begin
			ltr = pick_letter();
			send_item(OP_EVAL, ($urandom_range(0, 3) != 0) ? ltr : pick_operator(), $urandom());
			if ($urandom_range(0, 5) == 0) pause_idle($urandom_range(1, 12));
		end
		repeat (n) send_item(OP_EVAL, pick_operator(), $urandom());
	endtask

	initial begin
		int sent;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_NOP;
		hold_sink = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: underflow, unbound, bindings, every operator, special cases
		send_item(OP_EVAL, SYM_PLUS, '0);
		send_item(OP_EVAL, SYM_LO_A, '0);
		send_item(OP_BIND, SYM_LO_A, 32'h8000_0000);
		send_item(OP_BIND, SYM_LO_A, 32'd5);
		send_item(OP_BIND, SYM_UP_Z, '1);
		send_item(OP_BIND, SYM_LO_Z, 32'd0);
		send_item(OP_BIND, SYM_UP_A, 32'h7FFF_FFFF);
		send_item(OP_BIND, 8'hFF, 32'd3);
		send_item(OP_EVAL, SYM_LO_A, '0);
		send_item(OP_EVAL, SYM_UP_Z, '0);
		send_item(OP_EVAL, SYM_SLASH, '0);     // most negative / -1
		send_item(OP_EVAL, SYM_LO_Z, '0);
		send_item(OP_EVAL, SYM_SLASH, '0);     // divide by zero
		send_item(OP_EVAL, SYM_CARET, '0);     // x^0
		send_item(OP_EVAL, SYM_UP_Z, '0);
		send_item(OP_EVAL, SYM_CARET, '0);     // negative exponent
		send_item(OP_EVAL, SYM_UP_A, '0);
		send_item(OP_EVAL, SYM_STAR, '0);
		send_item(OP_EVAL, SYM_UP_A, '0);
		send_item(OP_EVAL, SYM_PLUS, '0);
		send_item(OP_EVAL, SYM_UP_A, '0);
		send_item(OP_EVAL, SYM_MINUS, '0);
		send_item(OP_EVAL, 8'h00, '0);
		send_item(OP_NOP, SYM_LO_A, '0);
		send_item(OP_CLEAR, 8'hFF, '1);

		// overflow: fill the stack past its depth with the receiver held off
		send_item(OP_BIND, SYM_LO_A + 8'd1, 32'd7);
		hold_sink = 1;
		fork
			begin
				int k;
				for (k = 0; k < 200; k++) @(posedge clk);
				hold_sink = 0;
			end
		join_none
		repeat (DEPTH + 3) send_item(OP_EVAL, SYM_LO_A + 8'd1, '0);
		send_item(OP_EVAL, SYM_CARET, '0);
		s_axis_tvalid <= 0;
		wait (pending == 0 && !hold_sink);
		send_item(OP_CLEAR, 8'd0, '0);

		// random: mostly well formed expressions, some noise
		sent = 0;
		while (sent < 700) begin
			if ($urandom_range(0, 9) < 7) begin
				send_expression();
				sent += 15;
			end else begin
				send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom()), $urandom());
				sent++;
			end
			if ($urandom_range(0, 9) == 0) send_item(OP_CLEAR, 8'($urandom()), $urandom());
			if ($urandom_range(0, 3) == 0) pause_idle($urandom_range(1, 20));
			if ($urandom_range(0, 49) == 0) begin
				s_axis_tvalid <= 0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
